@@ src/rlsw_pkg.sv @@
// rlsw_pkg: shared constants and codes for the serial RGB LED waveform block.
// No dependencies; used by the interfaces, the pixel store and the top level.
package rlsw_pkg;

    localparam int MAX_LEDS_DEF   = 256;
    localparam int TICK_BITS_DEF  = 12;

    localparam int REQ_W          = 2;
    localparam int LED_IDX_W      = 8;
    localparam int COLOR_W        = 8;
    localparam int PIXEL_W        = 3 * COLOR_W;
    localparam int BITS_PER_LED   = PIXEL_W;
    localparam int BIT_POS_W      = 5;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_TICK_W     = 12;
    localparam int LED_COUNT_W    = 9;

    localparam int BIT_PERIOD_RST = 60;
    localparam int HIGH_ZERO_RST  = 19;
    localparam int HIGH_ONE_RST   = 38;
    localparam int LED_COUNT_RST  = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_START = 2'd2
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_PERIOD = 2'd0,
        CFG_HIGH_ZERO  = 2'd1,
        CFG_HIGH_ONE   = 2'd2,
        CFG_LED_COUNT  = 2'd3
    } cfg_idx_t;

endpackage

@@ src/rlsw_if.sv @@
// rlsw_if: valid/ready channel interfaces for requests, results and config writes.
// Depends on rlsw_pkg for field widths.
interface rlsw_req_if;
    logic                               valid;
    logic                               ready;
    logic [rlsw_pkg::REQ_W-1:0]         req_type;
    logic [rlsw_pkg::LED_IDX_W-1:0]     led_index;
    logic [rlsw_pkg::COLOR_W-1:0]       red;
    logic [rlsw_pkg::COLOR_W-1:0]       green;
    logic [rlsw_pkg::COLOR_W-1:0]       blue;

    modport source (output valid, req_type, led_index, red, green, blue, input ready);
    modport sink   (input valid, req_type, led_index, red, green, blue, output ready);
endinterface

interface rlsw_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic write_rejected;

    modport source (output valid, line_level, busy_res, frame_done, write_rejected,
                    input ready);
    modport sink   (input valid, line_level, busy_res, frame_done, write_rejected,
                    output ready);
endinterface

interface rlsw_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rlsw_pkg::CFG_IDX_W-1:0]      index;
    logic [rlsw_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/rlsw_store.sv @@
// rlsw_store: pixel color memory, one write port and one read port, registered read.
// Depends on rlsw_pkg for the pixel width.
module rlsw_store #(
    parameter int DEPTH  = rlsw_pkg::MAX_LEDS_DEF,
    parameter int ADDR_W = 8
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [rlsw_pkg::PIXEL_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [rlsw_pkg::PIXEL_W-1:0] rd_data
);

    logic [rlsw_pkg::PIXEL_W-1:0] store_reg [DEPTH];
    logic [rlsw_pkg::PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= store_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/rgb_led_serial_waveform.sv @@
// rgb_led_serial_waveform: single-wire RGB LED waveform generator, GRB order, MSB first.
// Depends on rlsw_pkg, rlsw_if (channel interfaces) and rlsw_store (pixel memory).
//
// Usage:
//   req: one transaction per clock tick of the waveform. req_type tick only, pixel
//        write (led_index, red, green, blue) or frame start.
//   res: one transaction per accepted request: line level for that tick, busy flag,
//        frame done pulse and a flag for a write or start rejected while busy.
//   cfg: register writes (bit period, high times, LED count), always ready; write
//        only while idle. Timing changes apply from the next tick.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle; the output register drains while the next
//   request is taken. Next-LED colors are prefetched from the store a whole LED
//   ahead, so the single read port never stalls the stream.
// Reset: configuration returns to its defaults and the store is cleared by a pass
//   over all MAX_LEDS entries, one entry per cycle, during which req.ready is low.
// Stall: while res is held off with a result waiting, req.ready drops and the
//   waveform holds its place.
module rgb_led_serial_waveform #(
    parameter int MAX_LEDS  = rlsw_pkg::MAX_LEDS_DEF,
    parameter int TICK_BITS = rlsw_pkg::TICK_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rlsw_req_if.sink    req,
    rlsw_res_if.source  res,
    rlsw_cfg_if.sink    cfg
);

    localparam int TICK_W   = TICK_BITS;
    localparam int CTICK_W  = (TICK_BITS < rlsw_pkg::CFG_TICK_W) ? TICK_BITS
                                                                 : rlsw_pkg::CFG_TICK_W;
    localparam int ADDR_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int POS_W    = $clog2(MAX_LEDS + 1);
    localparam int CNT_W    = (POS_W > rlsw_pkg::LED_COUNT_W) ? POS_W
                                                              : rlsw_pkg::LED_COUNT_W;
    localparam int PIX_W    = rlsw_pkg::PIXEL_W;
    localparam int BP_W     = rlsw_pkg::BIT_POS_W;

    // configuration
    logic [TICK_W-1:0]                   bit_period_reg;
    logic [TICK_W-1:0]                   high_zero_reg;
    logic [TICK_W-1:0]                   high_one_reg;
    logic [rlsw_pkg::LED_COUNT_W-1:0]    led_count_reg;

    // frame state
    logic                                sending_reg, sending_next;
    logic [TICK_W-1:0]                   phase_reg, phase_next;
    logic [BP_W-1:0]                     bit_pos_reg, bit_pos_next;
    logic [CNT_W-1:0]                    led_pos_reg, led_pos_next;
    logic [PIX_W-1:0]                    shift_reg, shift_next;
    logic [PIX_W-1:0]                    head_reg, head_next;

    // store clearing pass
    logic                                clear_reg;
    logic [ADDR_W-1:0]                   clr_addr_reg;

    // result register
    logic                                res_valid_reg;
    logic                                res_line_reg;
    logic                                res_busy_reg;
    logic                                res_done_reg;
    logic                                res_rejected_reg;

    logic                                req_accept;
    rlsw_pkg::req_type_t                 req_code;
    logic [CNT_W-1:0]                    led_count_ext;
    logic [CNT_W-1:0]                    frame_len;
    logic [CNT_W-1:0]                    led_pos_inc;
    logic [PIX_W-1:0]                    pix_wdata;
    logic [PIX_W-1:0]                    rd_data;
    logic [ADDR_W-1:0]                   rd_addr;
    logic                                mem_wr_en;
    logic [ADDR_W-1:0]                   mem_wr_addr;
    logic [PIX_W-1:0]                    mem_wr_data;
    logic                                pix_wr;
    logic                                line_c, busy_c, done_c, rejected_c;
    logic [TICK_W-1:0]                   high_time;

    assign req_code      = rlsw_pkg::req_type_t'(req.req_type);
    assign req.ready     = !clear_reg && (!res_valid_reg || res.ready);
    assign req_accept    = req.valid && req.ready;
    assign cfg.ready     = 1'b1;

    assign led_count_ext = CNT_W'(led_count_reg);
    assign frame_len     = (led_count_ext > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
                                                              : led_count_ext;
    assign led_pos_inc   = led_pos_reg + CNT_W'(1);
    assign rd_addr       = led_pos_inc[ADDR_W-1:0];
    assign pix_wdata     = {req.green, req.red, req.blue};

    always_comb
    begin
        sending_next = sending_reg;
        phase_next   = phase_reg;
        bit_pos_next = bit_pos_reg;
        led_pos_next = led_pos_reg;
        shift_next   = shift_reg;
        head_next    = head_reg;
        pix_wr       = 1'b0;
        line_c       = 1'b0;
        busy_c       = 1'b0;
        done_c       = 1'b0;
        rejected_c   = 1'b0;
        high_time    = high_zero_reg;

        if (sending_reg)
        begin
            if (req_code == rlsw_pkg::REQ_WRITE || req_code == rlsw_pkg::REQ_START)
            begin
                rejected_c = 1'b1;
            end
        end
        else if (req_code == rlsw_pkg::REQ_WRITE)
        begin
            if (CNT_W'(req.led_index) < CNT_W'(MAX_LEDS))
            begin
                pix_wr = 1'b1;
                if (req.led_index == '0)
                begin
                    head_next = pix_wdata;
                end
            end
        end
        else if (req_code == rlsw_pkg::REQ_START)
        begin
            if (frame_len == '0)
            begin
                done_c = 1'b1;
            end
            else
            begin
                sending_next = 1'b1;
                phase_next   = '0;
                bit_pos_next = '0;
                led_pos_next = '0;
                shift_next   = head_reg;
            end
        end

        if (sending_next)
        begin
            high_time = shift_next[PIX_W-1] ? high_one_reg : high_zero_reg;
            busy_c    = 1'b1;
            line_c    = (phase_next < high_time);
            if (({1'b0, phase_next} + (TICK_W+1)'(1)) >= {1'b0, bit_period_reg})
            begin
                phase_next = '0;
                shift_next = {shift_next[PIX_W-2:0], 1'b0};
                if (bit_pos_next == BP_W'(rlsw_pkg::BITS_PER_LED - 1))
                begin
                    bit_pos_next = '0;
                    if ((led_pos_next + CNT_W'(1)) >= frame_len)
                    begin
                        sending_next = 1'b0;
                        done_c       = 1'b1;
                        led_pos_next = '0;
                        shift_next   = '0;
                    end
                    else
                    begin
                        // prefetched entry at led_pos_reg + 1
                        led_pos_next = led_pos_next + CNT_W'(1);
                        shift_next   = rd_data;
                    end
                end
                else
                begin
                    bit_pos_next = bit_pos_next + BP_W'(1);
                end
            end
            else
            begin
                phase_next = phase_next + TICK_W'(1);
            end
        end
    end

    always_comb
    begin
        if (clear_reg)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = '0;
        end
        else
        begin
            mem_wr_en   = req_accept && pix_wr;
            mem_wr_addr = ADDR_W'(req.led_index);
            mem_wr_data = pix_wdata;
        end
    end

    rlsw_store #(
        .DEPTH  (MAX_LEDS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= TICK_W'(rlsw_pkg::BIT_PERIOD_RST);
            high_zero_reg  <= TICK_W'(rlsw_pkg::HIGH_ZERO_RST);
            high_one_reg   <= TICK_W'(rlsw_pkg::HIGH_ONE_RST);
            led_count_reg  <= rlsw_pkg::LED_COUNT_W'(rlsw_pkg::LED_COUNT_RST);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (rlsw_pkg::cfg_idx_t'(cfg.index))
                rlsw_pkg::CFG_BIT_PERIOD: bit_period_reg <= TICK_W'(cfg.data[CTICK_W-1:0]);
                rlsw_pkg::CFG_HIGH_ZERO:  high_zero_reg  <= TICK_W'(cfg.data[CTICK_W-1:0]);
                rlsw_pkg::CFG_HIGH_ONE:   high_one_reg   <= TICK_W'(cfg.data[CTICK_W-1:0]);
                rlsw_pkg::CFG_LED_COUNT:
                    led_count_reg <= cfg.data[rlsw_pkg::LED_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(MAX_LEDS - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            phase_reg   <= '0;
            bit_pos_reg <= '0;
            led_pos_reg <= '0;
            shift_reg   <= '0;
            head_reg    <= '0;
        end
        else if (req_accept)
        begin
            sending_reg <= sending_next;
            phase_reg   <= phase_next;
            bit_pos_reg <= bit_pos_next;
            led_pos_reg <= led_pos_next;
            shift_reg   <= shift_next;
            head_reg    <= head_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            res_line_reg     <= line_c;
            res_busy_reg     <= busy_c;
            res_done_reg     <= done_c;
            res_rejected_reg <= rejected_c;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.line_level     = res_line_reg;
    assign res.busy_res       = res_busy_reg;
    assign res.frame_done     = res_done_reg;
    assign res.write_rejected = res_rejected_reg;

`ifndef NO_ASSERTIONS
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (phase_reg == '0 && bit_pos_reg == '0 && led_pos_reg == '0))
        else $error("idle with stale frame position");

    a_no_send_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> (!sending_reg && !req.ready))
        else $error("request path active during store clear");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_rejected_reg) |-> res_busy_reg)
        else $error("rejected transaction outside a frame");

    a_bit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg < BP_W'(rlsw_pkg::BITS_PER_LED))
        else $error("bit position out of range");
`endif

endmodule

@@ verif/rgb_led_serial_waveform_tb.sv @@
// rgb_led_serial_waveform_tb: checks the serial RGB LED waveform block against its own
// tick-by-tick model of the pixel store, bit timing and frame sequencing.
// Depends on rlsw_pkg, rlsw_if and the rgb_led_serial_waveform top level.
module rgb_led_serial_waveform_tb;

    localparam int TICK_W        = rlsw_pkg::CFG_TICK_W;
    localparam int CNT_W         = rlsw_pkg::LED_COUNT_W;
    localparam int PIX_W         = rlsw_pkg::PIXEL_W;
    localparam logic [rlsw_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int NUM_LEDS      = rlsw_pkg::MAX_LEDS_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_TICKS  = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int CHUNK_TICKS   = 16;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 40;
    localparam int LONG_TICKS    = 96;

    typedef struct packed {
        logic [rlsw_pkg::REQ_W-1:0]     kind;
        logic [rlsw_pkg::LED_IDX_W-1:0] led_index;
        logic [rlsw_pkg::COLOR_W-1:0]   red;
        logic [rlsw_pkg::COLOR_W-1:0]   green;
        logic [rlsw_pkg::COLOR_W-1:0]   blue;
    } led_request_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic write_rejected;
    } line_sample_t;

    logic clk;
    logic rst_n;

    rlsw_req_if req_ch ();
    rlsw_res_if res_ch ();
    rlsw_cfg_if cfg_ch ();

    rgb_led_serial_waveform DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // waveform model state
    logic [PIX_W-1:0]                   led_colors [NUM_LEDS];
    logic [TICK_W-1:0]                  tick_in_bit;
    logic [rlsw_pkg::BIT_POS_W-1:0]     bit_in_led;
    logic [CNT_W-1:0]                   led_in_frame;
    logic                               frame_active;
    logic [PIX_W-1:0]                   shift_reg;
    logic [TICK_W-1:0]                  period_reg;
    logic [TICK_W-1:0]                  zero_high_reg;
    logic [TICK_W-1:0]                  one_high_reg;
    logic [CNT_W-1:0]                   led_count_reg;

    led_request_t pending_requests [$];
    line_sample_t expected_samples [$];
    led_request_t offered;

    int  mismatch_count;
    int  sample_count;
    int  cycle_count;
    int  hold_left;
    bit  hold_armed;
    bit  hold_done;
    bit  no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic advance_waveform(input led_request_t rq);
        line_sample_t      s;
        logic [TICK_W-1:0] high_ticks;
        int                frame_leds;
        s = '0;
        frame_leds = (led_count_reg > NUM_LEDS) ? NUM_LEDS : int'(led_count_reg);
        if (frame_active)
        begin
            if (rq.kind == rlsw_pkg::REQ_WRITE || rq.kind == rlsw_pkg::REQ_START)
                s.write_rejected = 1'b1;
        end
        else if (rq.kind == rlsw_pkg::REQ_WRITE)
            led_colors[rq.led_index] = {rq.green, rq.red, rq.blue};
        else if (rq.kind == rlsw_pkg::REQ_START)
        begin
            if (frame_leds == 0)
                s.frame_done = 1'b1;
            else
            begin
                frame_active = 1'b1;
                tick_in_bit  = '0;
                bit_in_led   = '0;
                led_in_frame = '0;
                shift_reg    = led_colors[0];
            end
        end
        if (frame_active)
        begin
            high_ticks   = shift_reg[PIX_W-1] ? one_high_reg : zero_high_reg;
            s.busy_res   = 1'b1;
            s.line_level = (tick_in_bit < high_ticks);
            if (int'(tick_in_bit) + 1 >= int'(period_reg))
            begin
                tick_in_bit = '0;
                shift_reg   = shift_reg << 1;
                bit_in_led  = bit_in_led + 1'b1;
                if (bit_in_led >= rlsw_pkg::BITS_PER_LED)
                begin
                    bit_in_led   = '0;
                    led_in_frame = led_in_frame + 1'b1;
                    if (int'(led_in_frame) >= frame_leds)
                    begin
                        frame_active = 1'b0;
                        s.frame_done = 1'b1;
                        led_in_frame = '0;
                        shift_reg    = '0;
                    end
                    else
                        shift_reg = led_colors[led_in_frame];
                end
            end
            else
                tick_in_bit = tick_in_bit + 1'b1;
        end
        expected_samples.push_back(s);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.req_type  <= rlsw_pkg::REQ_TICK;
            req_ch.led_index <= '0;
            req_ch.red       <= '0;
            req_ch.green     <= '0;
            req_ch.blue      <= '0;
            foreach (led_colors[i])
                led_colors[i] = '0;
            tick_in_bit  = '0;
            bit_in_led   = '0;
            led_in_frame = '0;
            frame_active = 1'b0;
            shift_reg    = '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
                advance_waveform(offered);
            if (pending_requests.size() != 0 && (no_idle || $urandom_range(99) >= 32))
            begin
                offered = pending_requests.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.req_type  <= offered.kind;
                req_ch.led_index <= offered.led_index;
                req_ch.red       <= offered.red;
                req_ch.green     <= offered.green;
                req_ch.blue      <= offered.blue;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("transaction %0d: result with nothing expected", sample_count);
                    mismatch_count++;
                end
                else
                begin
                    line_sample_t want;
                    want = expected_samples.pop_front();
                    if (res_ch.line_level !== want.line_level
                        || res_ch.busy_res !== want.busy_res
                        || res_ch.frame_done !== want.frame_done
                        || res_ch.write_rejected !== want.write_rejected)
                    begin
                        if (mismatch_count < 10)
                            $display("transaction %0d: line/busy/done/rej expected %b%b%b%b, got %b%b%b%b",
                                     sample_count, want.line_level, want.busy_res,
                                     want.frame_done, want.write_rejected,
                                     res_ch.line_level, res_ch.busy_res,
                                     res_ch.frame_done, res_ch.write_rejected);
                        mismatch_count++;
                    end
                end
                sample_count++;
            end
            res_ch.ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 32);
        end
    end

    // receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rgb_led_serial_waveform_tb: FAIL");
            $finish;
        end
    end

    task automatic queue_request(input logic [rlsw_pkg::REQ_W-1:0] kind,
                                 input logic [7:0] idx,
                                 input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        led_request_t rq;
        rq = '{kind, idx, r, g, b};
        pending_requests.push_back(rq);
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || req_ch.valid || expected_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic finish_frame();
        drain();
        while (frame_active)
        begin
            repeat (CHUNK_TICKS)
                queue_request(rlsw_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
            drain();
        end
    endtask

    task automatic write_register(input rlsw_pkg::cfg_idx_t idx,
                                  input logic [rlsw_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            rlsw_pkg::CFG_BIT_PERIOD: period_reg    = value;
            rlsw_pkg::CFG_HIGH_ZERO:  zero_high_reg = value;
            rlsw_pkg::CFG_HIGH_ONE:   one_high_reg  = value;
            rlsw_pkg::CFG_LED_COUNT:  led_count_reg = value[CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_timing(input logic [11:0] period, input logic [11:0] zero_high,
                              input logic [11:0] one_high, input logic [11:0] leds);
        write_register(rlsw_pkg::CFG_BIT_PERIOD, period);
        write_register(rlsw_pkg::CFG_HIGH_ZERO, zero_high);
        write_register(rlsw_pkg::CFG_HIGH_ONE, one_high);
        write_register(rlsw_pkg::CFG_LED_COUNT, leds);
    endtask

    initial
    begin
        logic [rlsw_pkg::REQ_W-1:0] kind;
        logic [7:0]                 idx;
        int                         pick;

        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = rlsw_pkg::CFG_BIT_PERIOD;
        cfg_ch.data   = '0;
        hold_armed    = 1'b0;
        no_idle       = 1'b0;
        rst_n         = 1'b0;

        period_reg    = TICK_W'(rlsw_pkg::BIT_PERIOD_RST);
        zero_high_reg = TICK_W'(rlsw_pkg::HIGH_ZERO_RST);
        one_high_reg  = TICK_W'(rlsw_pkg::HIGH_ONE_RST);
        led_count_reg = CNT_W'(rlsw_pkg::LED_COUNT_RST);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, busy rejection, idle ticks
        set_timing(12'd3, 12'd1, 12'd2, 12'd2);
        queue_request(rlsw_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_request(REQ_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
        queue_request(rlsw_pkg::REQ_WRITE, 8'h00, 8'hff, 8'hff, 8'hff);
        queue_request(rlsw_pkg::REQ_WRITE, 8'hff, 8'h00, 8'hff, 8'h00);
        queue_request(rlsw_pkg::REQ_WRITE, 8'h02, 8'ha5, 8'h5a, 8'h3c);
        queue_request(rlsw_pkg::REQ_WRITE, 8'h01, 8'h80, 8'h01, 8'hfe);
        queue_request(rlsw_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_request(rlsw_pkg::REQ_WRITE, 8'h03, 8'h11, 8'h22, 8'h33);
        queue_request(rlsw_pkg::REQ_START, 8'hff, 8'hff, 8'hff, 8'hff);
        queue_request(REQ_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
        finish_frame();
        queue_request(rlsw_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
        finish_frame();

        // zero LEDs: done at once, stays idle
        write_register(rlsw_pkg::CFG_LED_COUNT, 12'd0);
        queue_request(rlsw_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_request(rlsw_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_request(rlsw_pkg::REQ_WRITE, 8'h03, 8'hc3, 8'h3c, 8'h99);
        finish_frame();

        // short periods, high time zero and beyond the period
        set_timing(12'd0, 12'd0, 12'd4095, 12'd2);
        queue_request(rlsw_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
        finish_frame();
        set_timing(12'd1, 12'd4095, 12'd0, 12'd2);
        queue_request(rlsw_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
        finish_frame();

        // random phases
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_timing(12'($urandom_range(5)), 12'($urandom_range(6)),
                       12'($urandom_range(6)), 12'($urandom_range(2)));
            no_idle = (phase == 3);
            if (phase == 2)
                hold_armed = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    kind = rlsw_pkg::REQ_WRITE;
                else if (pick < 50)
                    kind = rlsw_pkg::REQ_START;
                else if (pick < 95)
                    kind = rlsw_pkg::REQ_TICK;
                else
                    kind = REQ_UNUSED;
                idx = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(3));
                queue_request(kind, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                if ($urandom_range(39) == 0)
                    drain();
            end
            finish_frame();
            no_idle = 1'b0;
        end

        // longest bit period without idling, then a shorter period mid-frame
        set_timing(12'd4095, 12'd2048, 12'd4095, 12'd1);
        queue_request(rlsw_pkg::REQ_WRITE, 8'h00, 8'h0f, 8'hf0, 8'h81);
        queue_request(rlsw_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
        no_idle = 1'b1;
        repeat (LONG_TICKS)
            queue_request(rlsw_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        drain();
        write_register(rlsw_pkg::CFG_BIT_PERIOD, 12'd2);
        finish_frame();
        no_idle = 1'b0;

        drain();
        if (mismatch_count == 0)
            $display("rgb_led_serial_waveform_tb: PASS");
        else
            $display("rgb_led_serial_waveform_tb: FAIL");
        $finish;
    end
endmodule
